>>> hdl/assert_macros.svh
// Assertion helpers for the scheduler RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

>>> hdl/des_pkg.sv
package des_pkg;
  localparam int unsigned ReadyDepthDef = 16;
  localparam int unsigned DelayDepthDef = 8;
  localparam int unsigned EvW  = 40;
  localparam int unsigned RemW = 28;

  typedef enum logic [1:0] {
    OP_PUSH_DELAY = 2'd0,
    OP_PUSH_NOW   = 2'd1,
    OP_TICK       = 2'd2,
    OP_POP        = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]   op;
    logic [7:0]   code;
    logic signed [15:0] param;
    logic signed [15:0] extend;
    logic [30:0]  delay_ms;
    logic [15:0]  tick_count;
  } in_t;

  typedef struct packed {
    logic         accepted;
    logic         event_valid;
    logic [7:0]   event_code;
    logic signed [15:0] event_param;
    logic signed [15:0] event_extend;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DROP_RD, ST_DROP_CHK, ST_MOVE_RD, ST_MOVE_WR, ST_PUSH,
    ST_TICK_RD, ST_TICK_CHK, ST_POP_RD, ST_POPMV_RD, ST_POPMV_WR, ST_DONE
  } state_e;
endpackage

>>> hdl/delayed_event_scheduler_unit.sv
// Delayed event scheduler: one item in, one result beat out, one item at a time.
// Steps: an immediate push writes the ready FIFO; a pop reads the head and shifts the queue down;
// a delayed push first scans the table, compacting out any same-code entry, then appends;
// a tick walks every entry and moves each fired one to the ready FIFO, then compacts out its code.
// The next item is taken in the cycle after the result beat leaves; an output stall delays it.
// Reset: FSM and both counts clear; RAMs are not cleared, only slots below the counts are read.
`include "assert_macros.svh"
module delayed_event_scheduler_unit import des_pkg::*; #(
  parameter int unsigned READY_DEPTH = ReadyDepthDef,
  parameter int unsigned DELAY_DEPTH = DelayDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);
  localparam int unsigned RAW = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
  localparam int unsigned DAW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int unsigned RCW = $clog2(READY_DEPTH + 1);
  localparam int unsigned DCW = $clog2(DELAY_DEPTH + 1);
  localparam int unsigned DW  = EvW + RemW;

  state_e st_q, st_d;
  in_t    it_q, it_d;
  logic [RCW-1:0] rcnt_q, rcnt_d;
  logic [DCW-1:0] dcnt_q, dcnt_d;
  // walk index, compaction index
  logic [DCW-1:0] i_q, i_d, j_q, j_d;
  logic [RCW-1:0] k_q, k_d;
  // code being removed from the table; tick mode flag
  logic [7:0] dcode_q, dcode_d;
  logic       tick_q, tick_d;
  out_t res_q, res_d;
  logic ov_q, ov_d;

  // delay RAM port: {code,param,extend,remaining}
  logic            dwe;
  logic [DAW-1:0]  dwa, dra;
  logic [DW-1:0]   dwd, drd;
  logic            rwe;
  logic [RAW-1:0]  rwa, rra;
  logic [EvW-1:0]  rwd, rrd;

  des_ram #(.Width(DW), .Depth(DELAY_DEPTH)) u_dram (
    .clk_i, .we_i(dwe), .waddr_i(dwa), .wdata_i(dwd), .raddr_i(dra), .rdata_o(drd));
  des_ram #(.Width(EvW), .Depth(READY_DEPTH)) u_rram (
    .clk_i, .we_i(rwe), .waddr_i(rwa), .wdata_i(rwd), .raddr_i(rra), .rdata_o(rrd));

  // ms / 10 via reciprocal: floor(x*0xCCCCCCCD >> 35), split in two 32x16 halves
  logic [47:0] p_lo, p_hi;
  logic [63:0] prod;
  logic [27:0] dly;
  logic [31:0] ms32;
  assign ms32 = {1'b0, it_q.delay_ms};
  assign p_lo = 48'(ms32) * 48'(16'hCCCD);
  assign p_hi = 48'(ms32) * 48'(16'hCCCC);
  assign prod = 64'(p_lo) + {p_hi, 16'h0};
  assign dly  = (prod[62:35] == '0) ? 28'd1 : prod[62:35];

  logic [27:0] rem;
  logic [7:0]  rcode;
  assign rem   = drd[RemW-1:0];
  assign rcode = drd[DW-1 -: 8];

  assign in_stall_o = (st_q != ST_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o = res_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:     if (in_valid_i) begin
        case (op_e'(in_data_i.op))
          OP_PUSH_DELAY: st_d = ST_DROP_RD;
          OP_PUSH_NOW:   st_d = ST_PUSH;
          OP_TICK:       st_d = ST_TICK_RD;
          default:       st_d = ST_POP_RD;
        endcase
      end
      ST_DROP_RD:  st_d = (i_q < dcnt_q) ? ST_DROP_CHK : (tick_q ? ST_TICK_RD : ST_PUSH);
      ST_DROP_CHK: st_d = (rcode == dcode_q) ? ST_MOVE_RD : ST_DROP_RD;
      ST_MOVE_RD:  st_d = (32'(j_q) + 1 < 32'(dcnt_q)) ? ST_MOVE_WR : ST_DROP_RD;
      ST_MOVE_WR:  st_d = ST_MOVE_RD;
      ST_PUSH:     st_d = ST_DONE;
      ST_TICK_RD:  st_d = (i_q < dcnt_q) ? ST_TICK_CHK : ST_DONE;
      ST_TICK_CHK: st_d = (rem > 28'(it_q.tick_count)) ? ST_TICK_RD : ST_DROP_RD;
      ST_POP_RD:   st_d = (rcnt_q != '0) ? ST_POPMV_RD : ST_DONE;
      ST_POPMV_RD: st_d = (32'(k_q) + 1 < 32'(rcnt_q)) ? ST_POPMV_WR : ST_DONE;
      ST_POPMV_WR: st_d = ST_POPMV_RD;
      ST_DONE:     st_d = (!ov_q || !out_stall_i) ? ST_IDLE : ST_DONE;
      default:     st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    it_d = it_q; rcnt_d = rcnt_q; dcnt_d = dcnt_q; i_d = i_q; j_d = j_q; k_d = k_q;
    dcode_d = dcode_q; tick_d = tick_q; res_d = res_q;
    ov_d = ov_q && out_stall_i;
    dwe = 1'b0; dwa = DAW'(j_q); dwd = drd; dra = DAW'(i_q);
    rwe = 1'b0; rwa = RAW'(k_q); rwd = rrd; rra = RAW'(k_q);
    case (st_q)
      ST_IDLE: if (in_valid_i) begin
        it_d = in_data_i; i_d = '0; k_d = '0; res_d = '0;
        dcode_d = in_data_i.code;
        tick_d = (op_e'(in_data_i.op) == OP_TICK);
        dra = '0; rra = '0;
      end
      ST_DROP_RD: begin
        dra = DAW'(i_q);
      end
      ST_DROP_CHK: begin
        if (rcode == dcode_q) begin
          j_d = i_q; dra = DAW'(32'(i_q) + 1);
        end else begin
          i_d = i_q + 1'b1; dra = DAW'(32'(i_q) + 1);
        end
      end
      ST_MOVE_RD: begin
        dra = DAW'(32'(j_q) + 1);
        if (!(32'(j_q) + 1 < 32'(dcnt_q))) begin
          dcnt_d = dcnt_q - 1'b1; dra = DAW'(i_q);
        end
      end
      ST_MOVE_WR: begin
        dwe = 1'b1; dwa = DAW'(j_q); dwd = drd;
        j_d = j_q + 1'b1; dra = DAW'(32'(j_q) + 2);
      end
      ST_PUSH: begin
        res_d = '0;
        if (op_e'(it_q.op) == OP_PUSH_NOW || it_q.delay_ms == '0) begin
          if (32'(rcnt_q) < READY_DEPTH) begin
            rwe = 1'b1; rwa = RAW'(rcnt_q);
            rwd = {it_q.code, it_q.param, it_q.extend};
            rcnt_d = rcnt_q + 1'b1; res_d.accepted = 1'b1;
          end
        end else if (32'(dcnt_q) < DELAY_DEPTH) begin
          dwe = 1'b1; dwa = DAW'(dcnt_q);
          dwd = {it_q.code, it_q.param, it_q.extend, dly};
          dcnt_d = dcnt_q + 1'b1; res_d.accepted = 1'b1;
        end
        ov_d = 1'b1;
      end
      ST_TICK_RD: begin
        dra = DAW'(i_q);
        if (!(i_q < dcnt_q)) begin res_d = '0; ov_d = 1'b1; end
      end
      ST_TICK_CHK: begin
        if (rem > 28'(it_q.tick_count)) begin
          dwe = 1'b1; dwa = DAW'(i_q);
          dwd = {drd[DW-1:RemW], rem - 28'(it_q.tick_count)};
          i_d = i_q + 1'b1; dra = DAW'(32'(i_q) + 1);
        end else begin
          if (32'(rcnt_q) < READY_DEPTH) begin
            rwe = 1'b1; rwa = RAW'(rcnt_q); rwd = drd[DW-1:RemW];
            rcnt_d = rcnt_q + 1'b1;
          end
          dcode_d = rcode; dra = DAW'(i_q);
        end
      end
      ST_POP_RD: begin
        rra = '0; ov_d = (rcnt_q == '0);
        res_d = '0;
      end
      ST_POPMV_RD: begin
        if (k_q == '0) begin
          res_d.event_valid = 1'b1;
          {res_d.event_code, res_d.event_param, res_d.event_extend} = rrd;
        end
        rra = RAW'(32'(k_q) + 1);
        if (!(32'(k_q) + 1 < 32'(rcnt_q))) begin
          rcnt_d = rcnt_q - 1'b1; ov_d = 1'b1;
        end
      end
      ST_POPMV_WR: begin
        rwe = 1'b1; rwa = RAW'(k_q); rwd = rrd;
        k_d = k_q + 1'b1; rra = RAW'(32'(k_q) + 2);
      end
      default: ;
    endcase
  end

  // A fired entry leaves through a drop pass that scans from slot 0; the walk
  // then resumes at the slot it fired from, which now holds the next entry.
  logic [DCW-1:0] resume_q, resume_d;
  logic [DCW-1:0] i_fix;
  always_comb begin
    resume_d = resume_q;
    i_fix = i_d;
    if (st_q == ST_TICK_CHK && !(rem > 28'(it_q.tick_count))) begin
      resume_d = i_q; i_fix = '0;
    end
    if (st_q == ST_DROP_RD && !(i_q < dcnt_q) && tick_q) i_fix = resume_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; rcnt_q <= '0; dcnt_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; rcnt_q <= rcnt_d; dcnt_q <= dcnt_d; ov_q <= ov_d;
    end
  end
  always_ff @(posedge clk_i) begin
    it_q <= it_d; i_q <= i_fix; j_q <= j_d; k_q <= k_d; dcode_q <= dcode_d;
    tick_q <= tick_d; res_q <= res_d; resume_q <= resume_d;
  end

  `ASSERT_CLK(a_rcnt, clk_i, rst_ni, 32'(rcnt_q) <= READY_DEPTH, "ready count overflow")
  `ASSERT_CLK(a_dcnt, clk_i, rst_ni, 32'(dcnt_q) <= DELAY_DEPTH, "delay count overflow")
  `ASSERT_CLK(a_busy, clk_i, rst_ni, out_valid_o |-> st_q == ST_DONE, "result outside done")
  `ASSERT_CLK(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "beat lost")
endmodule

>>> hdl/des_ram.sv
module des_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                           wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                           rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import des_pkg::*;

  localparam int unsigned ReadyDepth = ReadyDepthDef;
  localparam int unsigned DelayDepth = DelayDepthDef;
  localparam int unsigned IdleLimit  = 20000;

  typedef struct packed {
    logic [7:0]         code;
    logic signed [15:0] param;
    logic signed [15:0] extend;
  } sched_ev_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  // Scoreboard model of the block: ready FIFO plus delay table.
  sched_ev_t   ready_q[$];
  sched_ev_t   pend_ev[$];
  int unsigned pend_rem[$];
  out_t        expected_beats[$];

  int unsigned err_count;
  int unsigned beats_seen;
  int unsigned idle_cycles;
  bit          src_gaps;
  bit          sink_gaps;
  int unsigned ops_seen[4];

  delayed_event_scheduler_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Remove every pending entry with this code, keeping order.
  function automatic void drop_pending(logic [7:0] code);
    int i;
    i = 0;
    while (i < pend_ev.size()) begin
      if (pend_ev[i].code == code) begin
        pend_ev.delete(i);
        pend_rem.delete(i);
      end else begin
        i++;
      end
    end
  endfunction

  function automatic bit ready_push(sched_ev_t ev);
    if (ready_q.size() >= ReadyDepth) return 1'b0;
    ready_q.push_back(ev);
    return 1'b1;
  endfunction

  // Predict the result beat of one accepted item and update the model.
  function automatic out_t sched_predict(in_t it);
    out_t      r;
    sched_ev_t ev;
    sched_ev_t fired;
    int unsigned d;
    int        i;
    r = '0;
    ev.code   = it.code;
    ev.param  = it.param;
    ev.extend = it.extend;
    case (op_e'(it.op))
      OP_PUSH_DELAY: begin
        drop_pending(it.code);
        if (it.delay_ms == 0) begin
          r.accepted = ready_push(ev);
        end else if (pend_ev.size() < DelayDepth) begin
          d = it.delay_ms / 10;
          if (d == 0) d = 1;
          pend_ev.push_back(ev);
          pend_rem.push_back(d);
          r.accepted = 1'b1;
        end
      end
      OP_PUSH_NOW: r.accepted = ready_push(ev);
      OP_TICK: begin
        i = 0;
        while (i < pend_ev.size()) begin
          if (pend_rem[i] > it.tick_count) begin
            pend_rem[i] -= it.tick_count;
            i++;
          end else begin
            fired = pend_ev[i];
            void'(ready_push(fired));
            drop_pending(fired.code);
          end
        end
      end
      default: begin
        if (ready_q.size() > 0) begin
          ev = ready_q.pop_front();
          r.event_valid  = 1'b1;
          r.event_code   = ev.code;
          r.event_param  = ev.param;
          r.event_extend = ev.extend;
        end
      end
    endcase
    return r;
  endfunction

  // Send one item; predict at acceptance. Valid stays up into the next call.
  task automatic send_item(in_t it);
    int unsigned gap;
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_beats.push_back(sched_predict(it));
    ops_seen[it.op]++;
  endtask

  function automatic in_t make_item(op_e op, logic [7:0] code, logic [30:0] ms,
                                    logic [15:0] ticks);
    in_t it;
    it.op         = op;
    it.code       = code;
    it.param      = 16'($urandom());
    it.extend     = 16'($urandom());
    it.delay_ms   = ms;
    it.tick_count = ticks;
    return it;
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected result beat %h", out_data_o);
      end else begin
        want = expected_beats.pop_front();
        if (out_data_o.accepted !== want.accepted ||
            out_data_o.event_valid !== want.event_valid ||
            out_data_o.event_code !== want.event_code ||
            out_data_o.event_param !== want.event_param ||
            out_data_o.event_extend !== want.event_extend) begin
          err_count++;
          if (err_count <= 10)
            $display({"mismatch: exp acc=%0b vld=%0b code=%0d p=%0d x=%0d",
                      "  got acc=%0b vld=%0b code=%0d p=%0d x=%0d"},
                     want.accepted, want.event_valid, want.event_code,
                     want.event_param, want.event_extend,
                     out_data_o.accepted, out_data_o.event_valid,
                     out_data_o.event_code, out_data_o.event_param,
                     out_data_o.event_extend);
        end
      end
    end
  end

  // Receiver stall bursts.
  initial begin
    int unsigned n;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_gaps && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 16);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: cycles with no beat accepted on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no progress");
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic test_pop_empty();
    send_item(make_item(OP_POP, 8'd0, '0, '0));
  endtask

  task automatic test_ready_fifo();
    in_t it;
    // fill past depth, nil code and extreme fields included
    for (int i = 0; i <= ReadyDepth; i++) begin
      it = make_item(OP_PUSH_NOW, i[7:0], '0, '0);
      if (i == 1) begin it.code = 8'hFF; it.param = 16'sh8000; it.extend = 16'sh7FFF; end
      if (i == 2) begin it.param = 16'sh7FFF; it.extend = 16'sh8000; end
      send_item(it);
    end
    for (int i = 0; i <= ReadyDepth; i++) send_item(make_item(OP_POP, 8'd0, '0, '0));
  endtask

  task automatic test_delay_table();
    // same-code replace, sub-10 ms, full table, zero delay, zero tick, big tick
    send_item(make_item(OP_PUSH_DELAY, 8'd5, 31'd3, '0));
    send_item(make_item(OP_PUSH_DELAY, 8'd5, 31'h7FFFFFFF, '0));
    for (int i = 0; i < DelayDepth + 1; i++)
      send_item(make_item(OP_PUSH_DELAY, 8'd10 + i[7:0], 31'(10 * (i + 1)), '0));
    send_item(make_item(OP_PUSH_DELAY, 8'd10, 31'd50, '0));
    send_item(make_item(OP_PUSH_DELAY, 8'd12, 31'd0, '0));
    send_item(make_item(OP_TICK, 8'd0, '0, 16'd0));
    send_item(make_item(OP_TICK, 8'd0, '0, 16'd3));
    send_item(make_item(OP_TICK, 8'd0, '0, 16'hFFFF));
    send_item(make_item(OP_TICK, 8'd0, '0, 16'hFFFF));
    repeat (4) send_item(make_item(OP_POP, 8'd0, '0, '0));
  endtask

  task automatic test_random(int unsigned count);
    in_t it;
    int unsigned sel;
    for (int unsigned k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      it  = make_item(OP_POP, 8'($urandom_range(0, 11)), '0, '0);
      if ($urandom_range(0, 9) == 0) it.code = 8'($urandom());
      if (sel < 30) begin
        it.op = OP_PUSH_DELAY;
        case ($urandom_range(0, 5))
          0:       it.delay_ms = 31'd0;
          1:       it.delay_ms = 31'($urandom_range(1, 9));
          2:       it.delay_ms = 31'($urandom());
          default: it.delay_ms = 31'($urandom_range(10, 2000));
        endcase
      end else if (sel < 45) begin
        it.op = OP_PUSH_NOW;
      end else if (sel < 70) begin
        it.op = OP_TICK;
        it.tick_count = ($urandom_range(0, 19) == 0) ? 16'($urandom()) :
                        16'($urandom_range(0, 60));
      end else begin
        it.op = OP_POP;
      end
      if (it.op != OP_PUSH_DELAY && $urandom_range(0, 3) == 0) it.delay_ms = 31'($urandom());
      if (it.op != OP_TICK && $urandom_range(0, 3) == 0) it.tick_count = 16'($urandom());
      send_item(it);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    err_count   = 0;
    beats_seen  = 0;
    idle_cycles = 0;
    src_gaps    = 1'b1;
    sink_gaps   = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_pop_empty();
    test_ready_fifo();
    test_delay_table();
    // sender holds off until the block has answered everything
    wait_drained();
    test_random(520);
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    test_random(80);
    wait_drained();
    repeat (400) @(posedge clk_i);
    $display("covered %0d result beats: %0d delayed pushes, %0d immediate pushes,",
             beats_seen, ops_seen[0], ops_seen[1]);
    $display("  %0d ticks and %0d pops with gaps and stalls on both sides",
             ops_seen[2], ops_seen[3]);
    if (err_count == 0 && expected_beats.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
